FILE: hw/rtl/yuv420_block_binarize_macros.svh
// assertion macros for the block binarizer
// no dependencies
`ifndef YUV420_BLOCK_BINARIZE_MACROS_SVH
`define YUV420_BLOCK_BINARIZE_MACROS_SVH
`ifndef SYNTHESIS
`define YBB_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("assertion failed");
`define YBB_ASSERT_RST(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("assertion failed");
`else
`define YBB_ASSERT(label, clk, rst_n, prop)
`define YBB_ASSERT_RST(label, clk, prop)
`endif
`endif

FILE: hw/rtl/ybb_pkg.sv
// package for the yuv 4:2:0 block binarizer: widths, constants, helpers
// no dependencies
package ybb_pkg;
  localparam int unsigned MAX_DIM_DEF = 4096;
  localparam int unsigned CFG_W = 13;
  localparam int unsigned IDX_W = 3;
  localparam logic [IDX_W-1:0] REG_EN     = 3'd0;
  localparam logic [IDX_W-1:0] REG_LEFT   = 3'd1;
  localparam logic [IDX_W-1:0] REG_TOP    = 3'd2;
  localparam logic [IDX_W-1:0] REG_RIGHT  = 3'd3;
  localparam logic [IDX_W-1:0] REG_BOTTOM = 3'd4;
  localparam logic [IDX_W-1:0] REG_FW     = 3'd5;
  localparam logic [IDX_W-1:0] REG_FH     = 3'd6;
  localparam logic [7:0] LUMA_WHITE = 8'd235;
  localparam logic [7:0] LUMA_BLACK = 8'd16;

  // per-block geometry flags
  typedef struct packed {
    logic [3:0] in_frame;
    logic [3:0] in_region;
    logic       touches;
  } geom_t;

  // floor(v/256) then clip to 0..255, v signed
  function automatic logic [7:0] clip_shr8(input logic signed [21:0] v);
    logic signed [13:0] s;
    s = 14'(v >>> 8);
    if (s < 0) clip_shr8 = 8'd0;
    else if (s > 14'sd255) clip_shr8 = 8'd255;
    else clip_shr8 = s[7:0];
  endfunction

  function automatic logic [7:0] clip_shr8_off(input logic signed [21:0] v);
    logic signed [14:0] s;
    s = 15'(v >>> 8) + 15'sd128;
    if (s < 0) clip_shr8_off = 8'd0;
    else if (s > 15'sd255) clip_shr8_off = 8'd255;
    else clip_shr8_off = s[7:0];
  endfunction
endpackage

FILE: hw/rtl/yuv420_block_binarize.sv
// top level of the yuv 4:2:0 block binarizer
// depends on ybb_pkg, ybb_pixel, ybb_geom and the macros header
//
// Takes one 2x2 luma block with its shared U/V per transaction and returns one
// result per transaction. Fully pipelined: one block per cycle sustained when
// out_ready holds. Stages to the output register: rgb products, rgb clip,
// threshold, channel sums, chroma products, chroma clip. Any downstream stall
// freezes the whole pipe; nothing is lost or repeated. No state between blocks.
`include "yuv420_block_binarize_macros.svh"
module yuv420_block_binarize #(
  parameter int unsigned MAX_DIM = ybb_pkg::MAX_DIM_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [2:0]  cfg_index,
  input  logic [12:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [10:0] in_block_col,
  input  logic [10:0] in_block_row,
  input  logic [7:0]  in_luma_top_left,
  input  logic [7:0]  in_luma_top_right,
  input  logic [7:0]  in_luma_bottom_left,
  input  logic [7:0]  in_luma_bottom_right,
  input  logic [7:0]  in_chroma_u_in,
  input  logic [7:0]  in_chroma_v_in,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_luma_out_top_left,
  output logic [7:0]  out_luma_out_top_right,
  output logic [7:0]  out_luma_out_bottom_left,
  output logic [7:0]  out_luma_out_bottom_right,
  output logic [7:0]  out_chroma_u_out,
  output logic [7:0]  out_chroma_v_out,
  output logic [3:0]  out_inside_mask
);
  localparam int NS = 6;

  // configuration registers
  logic        reg_en_r;
  logic [12:0] left_r, top_r, right_r, bottom_r, fw_r, fh_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      reg_en_r <= 1'b0;
      left_r <= '0; top_r <= '0; right_r <= '0; bottom_r <= '0;
      fw_r <= 13'd4096; fh_r <= 13'd4096;
    end else if (cfg_we) begin
      unique case (cfg_index)
        ybb_pkg::REG_EN:     reg_en_r <= cfg_data[0];
        ybb_pkg::REG_LEFT:   left_r   <= cfg_data;
        ybb_pkg::REG_TOP:    top_r    <= cfg_data;
        ybb_pkg::REG_RIGHT:  right_r  <= cfg_data;
        ybb_pkg::REG_BOTTOM: bottom_r <= cfg_data;
        ybb_pkg::REG_FW:     fw_r     <= cfg_data;
        ybb_pkg::REG_FH:     fh_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  // pipeline valid bits; whole pipe advances when the output can move
  logic [NS-1:0] vld_r;
  logic          adv;
  assign adv = !vld_r[NS-1] || out_ready;
  assign in_ready = adv;
  assign out_valid = vld_r[NS-1];

  always_ff @(posedge clk) begin
    if (!rst_n) vld_r <= '0;
    else if (adv) vld_r <= {vld_r[NS-2:0], in_valid};
  end

  logic [7:0] luma_in [4];
  assign luma_in[0] = in_luma_top_left;
  assign luma_in[1] = in_luma_top_right;
  assign luma_in[2] = in_luma_bottom_left;
  assign luma_in[3] = in_luma_bottom_right;

  // lanes: rgb ready after stage 2, threshold after stage 3
  logic [7:0] r_w [4], g_w [4], b_w [4];
  logic [3:0] white_w;
  for (genvar i = 0; i < 4; i++) begin : g_lane
    ybb_pixel u_pix (
      .clk(clk), .en0(adv), .en1(adv), .en2(adv),
      .luma(luma_in[i]), .u(in_chroma_u_in), .v(in_chroma_v_in),
      .r_o(r_w[i]), .g_o(g_w[i]), .b_o(b_w[i]), .white_o(white_w[i])
    );
  end

  // geometry computed in stage 1, then delayed alongside
  ybb_pkg::geom_t geom1, geom2_r, geom3_r;
  ybb_geom #(.MAX_DIM(MAX_DIM)) u_geom (
    .clk(clk), .en(adv), .block_col(in_block_col), .block_row(in_block_row),
    .reg_en(reg_en_r), .left(left_r), .top(top_r), .right(right_r),
    .bottom(bottom_r), .fw(fw_r), .fh(fh_r), .geom_o(geom1)
  );

  // payload delay line for luma and chroma pass-through
  logic [7:0] luma_d_r [NS-1][4];
  logic [7:0] u_d_r [NS-1];
  logic [7:0] v_d_r [NS-1];
  always_ff @(posedge clk) begin
    if (adv) begin
      luma_d_r[0] <= luma_in;
      u_d_r[0] <= in_chroma_u_in;
      v_d_r[0] <= in_chroma_v_in;
      for (int s = 1; s < NS - 1; s++) begin
        luma_d_r[s] <= luma_d_r[s-1];
        u_d_r[s] <= u_d_r[s-1];
        v_d_r[s] <= v_d_r[s-1];
      end
      geom2_r <= geom1;
      geom3_r <= geom2_r;
    end
  end

  // stage 3: rgb registered again to sit with the threshold
  logic [7:0] r3_r [4], g3_r [4], b3_r [4];
  always_ff @(posedge clk) begin
    if (adv) begin
      r3_r <= r_w; g3_r <= g_w; b3_r <= b_w;
    end
  end

  // stage 4: luma select, channel sums averaged by count (1, 2 or 4 -> shift)
  logic [7:0]  yo4_r [4];
  logic [7:0]  ra4_r, ga4_r, ba4_r;
  logic        rebuild4_r;
  logic [3:0]  mask4_r;
  logic [9:0]  sr, sg, sb;
  logic [2:0]  cnt;
  logic [7:0]  ra, ga, ba;
  logic [7:0]  bwv;
  always_comb begin
    sr = '0; sg = '0; sb = '0; cnt = '0;
    for (int i = 0; i < 4; i++) begin
      bwv = white_w[i] ? 8'd255 : 8'd0;
      if (geom3_r.in_frame[i]) begin
        cnt = cnt + 3'd1;
        sr = sr + 10'(geom3_r.in_region[i] ? bwv : r3_r[i]);
        sg = sg + 10'(geom3_r.in_region[i] ? bwv : g3_r[i]);
        sb = sb + 10'(geom3_r.in_region[i] ? bwv : b3_r[i]);
      end
    end
    // in-frame sets are rectangles so count is 0, 1, 2 or 4
    case (cnt)
      3'd4:    begin ra = sr[9:2]; ga = sg[9:2]; ba = sb[9:2]; end
      3'd2:    begin ra = sr[8:1]; ga = sg[8:1]; ba = sb[8:1]; end
      default: begin ra = sr[7:0]; ga = sg[7:0]; ba = sb[7:0]; end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int i = 0; i < 4; i++) begin
        yo4_r[i] <= (geom3_r.in_frame[i] && geom3_r.in_region[i])
          ? (white_w[i] ? ybb_pkg::LUMA_WHITE : ybb_pkg::LUMA_BLACK) : luma_d_r[2][i];
      end
      ra4_r <= ra; ga4_r <= ga; ba4_r <= ba;
      rebuild4_r <= geom3_r.touches && (cnt != 3'd0);
      mask4_r <= geom3_r.in_frame;
    end
  end

  // stage 5: chroma products
  logic signed [21:0] pu5_r, pv5_r;
  logic [7:0]  yo5_r [4];
  logic        rebuild5_r;
  logic [3:0]  mask5_r;
  logic signed [21:0] ra_s, ga_s, ba_s;
  assign ra_s = 22'(ra4_r);
  assign ga_s = 22'(ga4_r);
  assign ba_s = 22'(ba4_r);
  always_ff @(posedge clk) begin
    if (adv) begin
      pu5_r <= -22'sd38 * ra_s - 22'sd74 * ga_s + 22'sd112 * ba_s + 22'sd128;
      pv5_r <= 22'sd112 * ra_s - 22'sd94 * ga_s - 22'sd18 * ba_s + 22'sd128;
      yo5_r <= yo4_r;
      rebuild5_r <= rebuild4_r;
      mask5_r <= mask4_r;
    end
  end

  // stage 6: clip and output register
  logic [7:0] uo_r, vo_r, yo6_r [4];
  logic [3:0] mask6_r;
  always_ff @(posedge clk) begin
    if (adv) begin
      uo_r <= rebuild5_r ? ybb_pkg::clip_shr8_off(pu5_r) : u_d_r[4];
      vo_r <= rebuild5_r ? ybb_pkg::clip_shr8_off(pv5_r) : v_d_r[4];
      yo6_r <= yo5_r;
      mask6_r <= mask5_r;
    end
  end

  assign out_luma_out_top_left     = yo6_r[0];
  assign out_luma_out_top_right    = yo6_r[1];
  assign out_luma_out_bottom_left  = yo6_r[2];
  assign out_luma_out_bottom_right = yo6_r[3];
  assign out_chroma_u_out = uo_r;
  assign out_chroma_v_out = vo_r;
  assign out_inside_mask  = mask6_r;

  `YBB_ASSERT(a_stall_holds, clk, rst_n, out_valid && !out_ready |=> out_valid)
  `YBB_ASSERT(a_ready_when_empty, clk, rst_n, !out_valid |-> in_ready)
  `YBB_ASSERT(a_fill, clk, rst_n, in_valid && in_ready |=> vld_r[0])
  `YBB_ASSERT_RST(a_reset_empty, clk, !rst_n |=> vld_r == '0)
endmodule

FILE: hw/rtl/ybb_pixel.sv
// one pixel lane: yuv to rgb (two stages) and black/white threshold (one stage)
// depends on ybb_pkg
module ybb_pixel (
  input  logic       clk,
  input  logic       en0,
  input  logic       en1,
  input  logic       en2,
  input  logic [7:0] luma,
  input  logic [7:0] u,
  input  logic [7:0] v,
  output logic [7:0] r_o,
  output logic [7:0] g_o,
  output logic [7:0] b_o,
  output logic       white_o
);
  logic signed [21:0] pr_r, pg_r, pb_r;
  logic [7:0] r_r, g_r, b_r;
  logic signed [9:0] c, d, e;
  logic [19:0] gray;
  logic        white_r;

  assign c = 10'(signed'({2'b0, luma})) - 10'sd16;
  assign d = 10'(signed'({2'b0, u})) - 10'sd128;
  assign e = 10'(signed'({2'b0, v})) - 10'sd128;

  always_ff @(posedge clk) begin
    if (en0) begin
      pr_r <= 22'sd298 * c + 22'sd409 * e + 22'sd128;
      pg_r <= 22'sd298 * c - 22'sd100 * d - 22'sd208 * e + 22'sd128;
      pb_r <= 22'sd298 * c + 22'sd516 * d + 22'sd128;
    end
    if (en1) begin
      r_r <= ybb_pkg::clip_shr8(pr_r);
      g_r <= ybb_pkg::clip_shr8(pg_r);
      b_r <= ybb_pkg::clip_shr8(pb_r);
    end
    if (en2) white_r <= gray >= 20'd127500;
  end

  // rounded gray >= 128  <=>  299r+587g+114b+500 >= 128000
  assign gray = 20'd299 * r_r + 20'd587 * g_r + 20'd114 * b_r;
  assign r_o = r_r;
  assign g_o = g_r;
  assign b_o = b_r;
  assign white_o = white_r;
endmodule

FILE: hw/rtl/ybb_geom.sv
// block geometry: frame and region membership per pixel
// depends on ybb_pkg
module ybb_geom #(
  parameter int unsigned MAX_DIM = ybb_pkg::MAX_DIM_DEF
) (
  input  logic                     clk,
  input  logic                     en,
  input  logic [10:0]              block_col,
  input  logic [10:0]              block_row,
  input  logic                     reg_en,
  input  logic [ybb_pkg::CFG_W-1:0] left,
  input  logic [ybb_pkg::CFG_W-1:0] top,
  input  logic [ybb_pkg::CFG_W-1:0] right,
  input  logic [ybb_pkg::CFG_W-1:0] bottom,
  input  logic [ybb_pkg::CFG_W-1:0] fw,
  input  logic [ybb_pkg::CFG_W-1:0] fh,
  output ybb_pkg::geom_t           geom_o
);
  localparam int unsigned DW = $clog2(MAX_DIM + 1) > 14 ? $clog2(MAX_DIM + 1) : 14;
  logic [DW-1:0] x0, y0, w, h, l, t, rr, bb;
  ybb_pkg::geom_t g, g_r;

  always_comb begin
    x0 = DW'({block_col, 1'b0});
    y0 = DW'({block_row, 1'b0});
    w = (DW'(fw) > DW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(fw);
    h = (DW'(fh) > DW'(MAX_DIM)) ? DW'(MAX_DIM) : DW'(fh);
    l = DW'(left); t = DW'(top); rr = DW'(right); bb = DW'(bottom);
    for (int i = 0; i < 4; i++) begin
      g.in_frame[i] = (x0 + DW'(i & 1) < w) && (y0 + DW'(i >> 1) < h);
      g.in_region[i] = !reg_en || ((x0 + DW'(i & 1) >= l) && (x0 + DW'(i & 1) < rr)
                       && (y0 + DW'(i >> 1) >= t) && (y0 + DW'(i >> 1) < bb));
    end
    g.touches = !reg_en || ((x0 < rr) && (x0 + DW'(2) > l) && (y0 < bb) && (y0 + DW'(2) > t));
  end

  always_ff @(posedge clk) begin
    if (en) g_r <= g;
  end
  assign geom_o = g_r;
endmodule
